// ===== hdl/pfe_pkg.sv =====
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types and constants for the postfix expression evaluator: character
// codes, status codes, operator and state encodings.
// ----------------------------------------------------------------------------
`default_nettype none

package pfe_pkg;

    // Operand word
    typedef logic [31:0] t_word;
    localparam int WORD_W = 32;

    // Divider step count, one quotient bit per step
    localparam int DIV_STEPS = WORD_W;

    // Character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;   // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;   // '9'
    localparam logic [7:0] CH_PLUS  = 8'h2B;   // '+'
    localparam logic [7:0] CH_MINUS = 8'h2D;   // '-'
    localparam logic [7:0] CH_STAR  = 8'h2A;   // '*'
    localparam logic [7:0] CH_SLASH = 8'h2F;   // '/'
    localparam logic [7:0] CH_END   = 8'h29;   // ')'

    // Status / sticky error codes
    typedef logic [1:0] t_status;
    localparam t_status ERR_NONE    = 2'd0;
    localparam t_status ERR_UNDER   = 2'd1;
    localparam t_status ERR_OVER    = 2'd2;
    localparam t_status ERR_DIVZERO = 2'd3;

    // Arithmetic operators
    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_op;

    // Control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_WB
    } t_state;

endpackage : pfe_pkg

`default_nettype wire

// ===== hdl/pfe_stack_ram.sv =====
// ----------------------------------------------------------------------------
// pfe_stack_ram
// Operand stack storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_stack_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic           i_clk,
    input  wire logic           i_we,
    input  wire logic [AW-1:0]  i_waddr,
    input  wire pfe_pkg::t_word i_wdata,
    input  wire logic           i_re,
    input  wire logic [AW-1:0]  i_raddr,
    output pfe_pkg::t_word      o_rdata
);
    import pfe_pkg::*;

    t_word r_mem [DEPTH];
    t_word r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule : pfe_stack_ram

`default_nettype wire

// ===== hdl/pfe_div.sv =====
// ----------------------------------------------------------------------------
// pfe_div
// Signed 32-bit divider, quotient truncated toward zero. Restoring radix-2,
// one quotient bit per cycle on the magnitudes, sign applied at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_div (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire pfe_pkg::t_word i_dividend,
    input  wire pfe_pkg::t_word i_divisor,
    output logic                o_done,
    output pfe_pkg::t_word      o_quotient
);
    import pfe_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    t_word            r_rem;
    t_word            r_quo;
    t_word            r_dvs;

    logic [WORD_W+1:0] trial;
    t_word             mag_dividend;
    t_word             mag_divisor;

    assign mag_dividend = i_dividend[WORD_W-1] ? (WORD_W'(0) - i_dividend) : i_dividend;
    assign mag_divisor  = i_divisor[WORD_W-1]  ? (WORD_W'(0) - i_divisor)  : i_divisor;

    // Trial subtract of the divisor from the shifted partial remainder
    assign trial = {1'b0, r_rem, r_quo[WORD_W-1]} - {2'b00, r_dvs};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= mag_dividend;
            r_dvs <= mag_divisor;
            r_neg <= i_dividend[WORD_W-1] ^ i_divisor[WORD_W-1];
        end else if (r_busy) begin
            if (!trial[WORD_W+1]) begin
                r_rem <= trial[WORD_W-1:0];
            end else begin
                r_rem <= {r_rem[WORD_W-2:0], r_quo[WORD_W-1]};
            end
            r_quo <= {r_quo[WORD_W-2:0], ~trial[WORD_W+1]};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (WORD_W'(0) - r_quo) : r_quo;

    // Done pulses only at the end of a run, never during one
    a_done_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy && $past(r_busy))
        else $error("divider done without a finished run");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");

endmodule : pfe_div

`default_nettype wire

// ===== hdl/postfix_expression_evaluator.sv =====
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Evaluates a postfix expression fed one ASCII character per word. Digits
// push, + - * / pop two and push one, ')' emits the top of stack with the
// sticky status and clears the stack.
//
//   Channel  Dir  Word contents
//   s_axis   in   tdata[7:0] char_code
//   m_axis   out  tdata[31:0] value, tuser[1:0] status
//
// Sequence: a digit, ')' or an ignored character is handled on acceptance. + - *
// pass through accept with stack read, execute and write back; '/' adds the wait
// on the 32-step iterative divider between execute and write back, except by zero.
// The top of stack lives in a register; the entry below it is read from the
// stack memory and results are written back to it.
// Reset: synchronous active low; clears count, error and control; the stack
// memory is not cleared and needs no clearing pass.
// Stalls: s_axis_tready is low while an operator is in progress and while a
// result waits in the output register without m_axis_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input characters
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,    // [7:0] char_code
    // Results
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,    // [31:0] value
    output logic [1:0]       m_axis_tuser     // [1:0] status
);
    import pfe_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // Registers and next values
    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    t_status       r_err, n_err;
    t_word         r_top, n_top;
    t_op           r_op, n_op;
    t_word         r_a, n_a;
    logic          r_bsel, n_bsel;
    t_word         r_res, n_res;
    logic [AW-1:0] r_waddr, n_waddr;
    logic [CW-1:0] r_newcnt, n_newcnt;
    logic          r_out_valid, n_out_valid;
    t_word         r_out_value, n_out_value;
    t_status       r_out_status, n_out_status;

    // Memory and divider hookup
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_word         ram_wdata;
    logic          ram_re;
    t_word         ram_rdata;
    logic          div_start;
    logic          div_done;
    t_word         div_quo;
    t_word         opnd_b;

    // Decode
    logic          acc;
    logic          is_digit, is_op, is_end;
    t_op           dec_op;
    logic [7:0]    digit_val;
    logic          full, two_plus;
    logic [CW-1:0] cnt_m1, cnt_m2;

    assign acc      = s_axis_tvalid && s_axis_tready;
    assign is_digit = (s_axis_tdata >= CH_ZERO) && (s_axis_tdata <= CH_NINE);
    assign is_op    = (s_axis_tdata == CH_PLUS) || (s_axis_tdata == CH_MINUS) ||
                      (s_axis_tdata == CH_STAR) || (s_axis_tdata == CH_SLASH);
    assign is_end   = (s_axis_tdata == CH_END);
    assign digit_val = s_axis_tdata - CH_ZERO;
    assign full     = (r_count == CW'(STACK_DEPTH));
    assign two_plus = (r_count >= CW'(2));
    assign cnt_m1   = r_count - CW'(1);
    assign cnt_m2   = r_count - CW'(2);
    assign opnd_b   = r_bsel ? ram_rdata : '0;

    always_comb begin
        unique case (s_axis_tdata)
            CH_PLUS:  dec_op = OP_ADD;
            CH_MINUS: dec_op = OP_SUB;
            CH_STAR:  dec_op = OP_MUL;
            default:  dec_op = OP_DIV;
        endcase
    end

    assign s_axis_tready = (r_state == ST_IDLE) && (!r_out_valid || m_axis_tready);

    // Stack memory: read the entry under the top when an operator arrives on a stack of two or more
    assign ram_re = acc && is_op && two_plus;

    pfe_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (cnt_m2[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    pfe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (opnd_b),
        .i_divisor  (r_a),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (acc && is_op) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (r_op == OP_DIV && r_a != '0) n_state = ST_DIV;
                else                             n_state = ST_WB;
            end
            ST_DIV: begin
                if (div_done) n_state = ST_WB;
            end
            ST_WB: begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and stack updates per state
    always_comb begin
        n_count      = r_count;
        n_err        = r_err;
        n_top        = r_top;
        n_op         = r_op;
        n_a          = r_a;
        n_bsel       = r_bsel;
        n_res        = r_res;
        n_waddr      = r_waddr;
        n_newcnt     = r_newcnt;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        ram_we       = 1'b0;
        ram_waddr    = r_waddr;
        ram_wdata    = r_res;
        div_start    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (acc && is_digit) begin
                    // push, or drop on a full stack
                    if (full) begin
                        if (r_err == ERR_NONE) n_err = ERR_OVER;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = r_count[AW-1:0];
                        ram_wdata = {{(WORD_W-4){1'b0}}, digit_val[3:0]};
                        n_top     = {{(WORD_W-4){1'b0}}, digit_val[3:0]};
                        n_count   = r_count + CW'(1);
                    end
                end else if (acc && is_op) begin
                    // pop A from the top register, B from memory
                    n_op     = dec_op;
                    n_a      = (r_count != '0) ? r_top : '0;
                    n_bsel   = two_plus;
                    n_waddr  = two_plus ? cnt_m2[AW-1:0] : '0;
                    n_newcnt = two_plus ? cnt_m1 : CW'(1);
                    if (!two_plus && r_err == ERR_NONE) n_err = ERR_UNDER;
                end else if (acc && is_end) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = (r_count != '0) ? r_top : '0;
                    n_out_status = (r_err == ERR_NONE && r_count == '0) ? ERR_UNDER : r_err;
                    n_count      = '0;
                    n_err        = ERR_NONE;
                end
            end
            ST_EXEC: begin
                case (r_op)
                    OP_ADD: n_res = opnd_b + r_a;
                    OP_SUB: n_res = opnd_b - r_a;
                    OP_MUL: n_res = opnd_b * r_a;
                    default: begin
                        if (r_a == '0) begin
                            n_res = '0;
                            if (r_err == ERR_NONE) n_err = ERR_DIVZERO;
                        end else begin
                            div_start = 1'b1;
                        end
                    end
                endcase
            end
            ST_DIV: begin
                if (div_done) n_res = div_quo;
            end
            ST_WB: begin
                ram_we  = 1'b1;
                n_top   = r_res;
                n_count = r_newcnt;
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_err       <= ERR_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_top        <= n_top;
        r_op         <= n_op;
        r_a          <= n_a;
        r_bsel       <= n_bsel;
        r_res        <= n_res;
        r_waddr      <= n_waddr;
        r_newcnt     <= n_newcnt;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tuser  = r_out_status;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && is_end |=> r_count == '0 && r_err == ERR_NONE && r_out_valid)
        else $error("end of expression did not clear stack");
    a_div_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == ST_DIV)
        else $error("divider finished outside divide state");
    a_op_writes_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_WB |=> r_count != '0 && r_state == ST_IDLE)
        else $error("write back left stack empty");

endmodule : postfix_expression_evaluator

`default_nettype wire
